// ===== src/ksq_pkg.sv =====
// Shared types, codes and constants for the keyboard scancode sequencer.
// No dependencies; used by the controller, the datapath and the top level.
package ksq_pkg;

  localparam int KEY_CODES_DEF = 512;
  localparam int MAX_HELD_DEF  = 64;

  localparam logic [6:0] COMPOSE_RESET = 7'h57;

  localparam logic [1:0] KIND_KEY        = 2'd0;
  localparam logic [1:0] KIND_RST_SEND   = 2'd1;
  localparam logic [1:0] KIND_RST_SILENT = 2'd2;

  localparam logic [9:0] CODE_PAUSE = 10'h245;
  localparam logic [7:0] BYTE_EXT   = 8'hE0;
  localparam logic [2:0] PAUSE_LEN  = 3'd6;

  localparam logic [1:0] ADDR_COMP = 2'd0;
  localparam logic [1:0] ADDR_KEY  = 2'd1;
  localparam logic [1:0] ADDR_WALK = 2'd2;

  localparam logic [1:0] EM_KEY     = 2'd0;
  localparam logic [1:0] EM_COMPOSE = 2'd1;
  localparam logic [1:0] EM_PAUSE   = 2'd2;
  localparam logic [1:0] EM_WALK    = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       mem_re;
    logic       mem_we;
    logic       wr_bit;
    logic [1:0] addr_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       walk_start;
    logic       walk_send;
    logic       walk_inc;
    logic       rem_dec;
    logic       set_mode;
    logic [1:0] mode;
    logic       seq_inc;
    logic       load_out;
  } ksq_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       count_zero;
    logic       count_full;
    logic       code_is_comp;
    logic       code_is_comp_rel;
    logic       code_rel;
    logic       code_special;
    logic       code_pause;
    logic       key_in_range;
    logic       rd_bit;
    logic       rem_one;
    logic       walk_at_end;
    logic       walk_send;
    logic       emit_last;
    logic       out_free;
  } ksq_stat_t;

  function automatic logic [7:0] pause_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'hE1;
      3'd1:    b = 8'h1D;
      3'd2:    b = 8'h45;
      3'd3:    b = 8'hE1;
      3'd4:    b = 8'h9D;
      3'd5:    b = 8'hC5;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/keyboard_scancode_sequencer.sv =====
// Top level of the keyboard scancode sequencer.
// Depends on ksq_pkg, ksq_ctrl and ksq_datapath.
//
// Input items (kind, code) arrive on in_valid/in_ready; scancode bytes leave
// on out_valid/out_ready as (scan_byte, last), with last set on the final
// byte caused by an item. The compose key code is written through cfg_wr_en
// and cfg_wr_data; the user must do so only while the block is idle, which
// the block itself leaves unchecked. After reset the held-key memory is
// cleared one entry per cycle, with in_ready low; the compose code returns
// to 0x57. One item is worked on at a time. A key event is decoded in
// S_DECIDE and the check states, and its bytes are then loaded into the
// output register one after another from S_EMIT. A release-all walk reads
// the held-key memory through its single port, each entry in S_WREAD and
// S_WCHK, stopping after the highest held key. When the receiver stalls,
// the pending byte stays in the output register and the controller waits.
module keyboard_scancode_sequencer #(
  parameter int KEY_CODES = ksq_pkg::KEY_CODES_DEF,
  parameter int MAX_HELD  = ksq_pkg::MAX_HELD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [9:0] code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] scan_byte,
  output logic       last
);

  ksq_pkg::ksq_cmd_t  cmd;
  ksq_pkg::ksq_stat_t stat;

  ksq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ksq_datapath #(
    .KEY_CODES (KEY_CODES),
    .MAX_HELD  (MAX_HELD)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .kind        (kind),
    .code        (code),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .scan_byte   (scan_byte),
    .last        (last)
  );

endmodule

// ===== src/ksq_datapath.sv =====
// Datapath of the scancode sequencer: held-key memory, counters, byte select
// and output register. Depends on ksq_pkg; driven by ksq_ctrl.
module ksq_datapath #(
  parameter int KEY_CODES = ksq_pkg::KEY_CODES_DEF,
  parameter int MAX_HELD  = ksq_pkg::MAX_HELD_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data,
  input  logic [1:0]        kind,
  input  logic [9:0]        code,
  input  ksq_pkg::ksq_cmd_t cmd,
  output ksq_pkg::ksq_stat_t stat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [7:0]        scan_byte,
  output logic              last
);

  localparam int AW = $clog2(KEY_CODES);
  localparam int CW = $clog2(MAX_HELD + 1);

  logic             mem [KEY_CODES];
  logic             rd_bit;
  logic [AW-1:0]    addr;
  logic [6:0]       compose;
  logic [1:0]       kind_r;
  logic [9:0]       code_r;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    rem;
  logic [AW-1:0]    walk_addr;
  logic             walk_send;
  logic [1:0]       mode;
  logic [2:0]       seq;
  logic [8:0]       key_idx;
  logic [7:0]       cur_byte;
  logic             cur_last;
  logic             out_free;

  assign key_idx  = {code_r[8], 1'b0, code_r[6:0]};
  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (cmd.addr_sel)
      ksq_pkg::ADDR_COMP: addr = AW'(compose);
      ksq_pkg::ADDR_KEY:  addr = key_idx[AW-1:0];
      default:            addr = walk_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[addr] <= cmd.wr_bit;
    end
    if (cmd.mem_re) begin
      rd_bit <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compose <= ksq_pkg::COMPOSE_RESET;
    end else if (cfg_wr_en) begin
      compose <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind;
      code_r <= code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rem       <= '0;
      walk_addr <= '0;
      walk_send <= 1'b0;
    end else begin
      if (cmd.walk_start) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt <= cnt - CW'(1);
      end
      if (cmd.walk_start) begin
        rem       <= cnt;
        walk_addr <= '0;
        walk_send <= cmd.walk_send;
      end else begin
        if (cmd.rem_dec) begin
          rem <= rem - CW'(1);
        end
        if (cmd.walk_inc) begin
          walk_addr <= walk_addr + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_mode) begin
      mode <= cmd.mode;
      seq  <= '0;
    end else if (cmd.seq_inc) begin
      seq <= seq + 3'd1;
    end
  end

  always_comb begin
    case (mode)
      ksq_pkg::EM_KEY: begin
        cur_byte = (code_r[8] && seq == 3'd0) ? ksq_pkg::BYTE_EXT : code_r[7:0];
        cur_last = !code_r[8] || seq == 3'd1;
      end
      ksq_pkg::EM_COMPOSE: begin
        cur_byte = {seq != 3'd0, compose};
        cur_last = seq == 3'd1;
      end
      ksq_pkg::EM_PAUSE: begin
        cur_byte = ksq_pkg::pause_byte(seq);
        cur_last = seq == ksq_pkg::PAUSE_LEN - 3'd1;
      end
      ksq_pkg::EM_WALK: begin
        cur_byte = {1'b1, walk_addr[6:0]};
        cur_last = rem == CW'(1);
      end
      default: begin
        cur_byte = '0;
        cur_last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      scan_byte <= cur_byte;
      last      <= cur_last;
    end
  end

  always_comb begin
    stat.kind             = kind_r;
    stat.count_zero       = cnt == '0;
    stat.count_full       = cnt >= CW'(MAX_HELD);
    stat.code_is_comp     = code_r == {3'b000, compose};
    stat.code_is_comp_rel = code_r == {3'b001, compose};
    stat.code_rel         = code_r[7];
    stat.code_special     = code_r[9];
    stat.code_pause       = code_r == ksq_pkg::CODE_PAUSE;
    stat.key_in_range     = {1'b0, key_idx} < 10'(KEY_CODES);
    stat.rd_bit           = rd_bit;
    stat.rem_one          = rem == CW'(1);
    stat.walk_at_end      = walk_addr == AW'(KEY_CODES - 1);
    stat.walk_send        = walk_send;
    stat.emit_last        = cur_last;
    stat.out_free         = out_free;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_HELD))
    else $error("held-key count beyond its limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("output register loaded while a byte is still pending");

  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.rem_dec |-> rem != '0)
    else $error("release walk found more held keys than counted");
`endif

endmodule

// ===== src/ksq_ctrl.sv =====
// Controller state machine of the scancode sequencer.
// Depends on ksq_pkg; issues commands to ksq_datapath and reads its status.
module ksq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ksq_pkg::ksq_stat_t stat,
  output ksq_pkg::ksq_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECIDE   = 4'd2;
  localparam logic [3:0] S_CHK_COMP = 4'd3;
  localparam logic [3:0] S_CREL     = 4'd4;
  localparam logic [3:0] S_CHK_KEY  = 4'd5;
  localparam logic [3:0] S_EMIT     = 4'd6;
  localparam logic [3:0] S_WREAD    = 4'd7;
  localparam logic [3:0] S_WCHK     = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       key_held;

  assign in_ready = state == S_IDLE;
  assign key_held = stat.rd_bit && stat.key_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.mem_we   = 1'b1;
        cmd.addr_sel = ksq_pkg::ADDR_WALK;
        cmd.walk_inc = 1'b1;
        if (stat.walk_at_end) begin
          cmd.walk_start = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.kind == ksq_pkg::KIND_RST_SEND || stat.kind == ksq_pkg::KIND_RST_SILENT) begin
          if (stat.count_zero) begin
            state_next = S_IDLE;
          end else begin
            cmd.walk_start = 1'b1;
            cmd.walk_send  = stat.kind == ksq_pkg::KIND_RST_SEND;
            state_next     = S_WREAD;
          end
        end else if (stat.kind == ksq_pkg::KIND_KEY) begin
          if (stat.count_zero && stat.code_is_comp) begin
            cmd.mem_we   = 1'b1;
            cmd.wr_bit   = 1'b1;
            cmd.addr_sel = ksq_pkg::ADDR_COMP;
            cmd.cnt_inc  = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.mem_re   = 1'b1;
            cmd.addr_sel = ksq_pkg::ADDR_COMP;
            state_next   = S_CHK_COMP;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CHK_COMP: begin
        if (stat.code_is_comp_rel) begin
          if (stat.rd_bit) begin
            cmd.mem_we   = 1'b1;
            cmd.addr_sel = ksq_pkg::ADDR_COMP;
            cmd.cnt_dec  = 1'b1;
          end
          state_next = S_CREL;
        end else if (stat.rd_bit && stat.code_rel) begin
          state_next = S_IDLE;
        end else if (stat.code_special) begin
          if (stat.code_pause) begin
            cmd.set_mode = 1'b1;
            cmd.mode     = ksq_pkg::EM_PAUSE;
            state_next   = S_EMIT;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          cmd.mem_re   = 1'b1;
          cmd.addr_sel = ksq_pkg::ADDR_KEY;
          state_next   = S_CHK_KEY;
        end
      end
      S_CREL: begin
        if (stat.count_zero) begin
          cmd.set_mode = 1'b1;
          cmd.mode     = ksq_pkg::EM_COMPOSE;
          state_next   = S_EMIT;
        end else begin
          cmd.walk_start = 1'b1;
          cmd.walk_send  = 1'b1;
          state_next     = S_WREAD;
        end
      end
      S_CHK_KEY: begin
        if (stat.code_rel && !key_held) begin
          state_next = S_IDLE;
        end else if (!stat.code_rel && stat.key_in_range && !key_held && stat.count_full) begin
          state_next = S_IDLE;
        end else begin
          cmd.addr_sel = ksq_pkg::ADDR_KEY;
          if (stat.code_rel) begin
            cmd.mem_we  = 1'b1;
            cmd.cnt_dec = 1'b1;
          end else if (stat.key_in_range && !key_held) begin
            cmd.mem_we  = 1'b1;
            cmd.wr_bit  = 1'b1;
            cmd.cnt_inc = 1'b1;
          end
          cmd.set_mode = 1'b1;
          cmd.mode     = ksq_pkg::EM_KEY;
          state_next   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (stat.emit_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.seq_inc = 1'b1;
          end
        end
      end
      S_WREAD: begin
        cmd.mem_re   = 1'b1;
        cmd.mem_we   = 1'b1;
        cmd.addr_sel = ksq_pkg::ADDR_WALK;
        if (stat.walk_send) begin
          cmd.set_mode = 1'b1;
          cmd.mode     = ksq_pkg::EM_WALK;
        end
        state_next = S_WCHK;
      end
      S_WCHK: begin
        if (!stat.rd_bit) begin
          cmd.walk_inc = 1'b1;
          state_next   = S_WREAD;
        end else if (!stat.walk_send || stat.out_free) begin
          cmd.load_out = stat.walk_send;
          cmd.rem_dec  = 1'b1;
          if (stat.rem_one) begin
            state_next = S_IDLE;
          end else begin
            cmd.walk_inc = 1'b1;
            state_next   = S_WREAD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_WCHK && stat.rd_bit && stat.walk_at_end) |-> stat.rem_one)
    else $error("held key found at the end of the map with more still counted");

  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new item taken before the previous one was decoded");

  a_clear_no_items: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !cmd.capture && !cmd.load_out)
    else $error("item activity during the clearing pass");
`endif

endmodule

// ===== tb/tb_keyboard_scancode_sequencer.sv =====
// Self-checking testbench for keyboard_scancode_sequencer.
// Depends on ksq_pkg and the RTL; an internal predictor tracks held keys and
// the compose code and checks every scancode byte under random backpressure.
`timescale 1ns / 1ps

module tb_keyboard_scancode_sequencer;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int NUM_KEYS = ksq_pkg::KEY_CODES_DEF;
  localparam int HELD_LIMIT = ksq_pkg::MAX_HELD_DEF;
  localparam int SETTLE_CYCLES = 2 * ksq_pkg::KEY_CODES_DEF + 100;
  localparam logic [7:0] PAUSE_SEQ [6] = '{8'hE1, 8'h1D, 8'h45, 8'hE1, 8'h9D, 8'hC5};

  typedef struct packed {
    logic [7:0] scan;
    logic       fin;
  } scan_exp_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = 7'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] kind = ksq_pkg::KIND_KEY;
  logic [9:0] code = 10'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] scan_byte;
  logic       last;

  bit         key_down [NUM_KEYS];
  int         held_total;
  logic [6:0] compose_now;
  logic [7:0] burst_bytes [$];
  scan_exp_t  pending_bytes [$];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold_left = 0;
  int rx_stall_left = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  int mismatch_count = 0;

  keyboard_scancode_sequencer DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .code(code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .scan_byte(scan_byte),
    .last(last)
  );

  always #2 clk = ~clk;

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void hold_key(input logic [8:0] idx);
    if (!key_down[idx]) begin
      key_down[idx] = 1'b1;
      held_total++;
    end
  endfunction

  function automatic void lift_key(input logic [8:0] idx);
    if (key_down[idx]) begin
      key_down[idx] = 1'b0;
      if (held_total > 0) held_total--;
    end
  endfunction

  function automatic void release_every_key(input bit send);
    if (send && held_total != 0) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (key_down[i]) burst_bytes.push_back(8'(i) | 8'h80);
      end
    end
    for (int i = 0; i < NUM_KEYS; i++) key_down[i] = 1'b0;
    held_total = 0;
  endfunction

  function automatic void predict_key_event(input logic [9:0] c);
    logic [8:0] comp_idx;
    logic [8:0] rel_idx;
    comp_idx = {2'b00, compose_now};
    rel_idx = c[8:0] & 9'h17F;
    if (held_total == 0 && c == {3'b000, compose_now}) begin
      hold_key(comp_idx);
    end else if (c == {3'b001, compose_now}) begin
      lift_key(comp_idx);
      if (held_total == 0) begin
        burst_bytes.push_back({1'b0, compose_now});
        burst_bytes.push_back({1'b1, compose_now});
      end else begin
        release_every_key(1'b1);
      end
    end else if (key_down[comp_idx] && c[7]) begin
    end else if (c[9]) begin
      if (c == ksq_pkg::CODE_PAUSE) begin
        for (int i = 0; i < 6; i++) burst_bytes.push_back(PAUSE_SEQ[i]);
      end
    end else if (c[7] && !key_down[rel_idx]) begin
    end else if (!c[7] && !key_down[c[8:0]] && held_total >= HELD_LIMIT) begin
    end else begin
      if (c[8]) burst_bytes.push_back(ksq_pkg::BYTE_EXT);
      burst_bytes.push_back(c[7:0]);
      if (c[7]) lift_key(rel_idx);
      else hold_key(c[8:0]);
    end
  endfunction

  function automatic void predict_scancodes(input logic [1:0] k, input logic [9:0] c);
    scan_exp_t e;
    burst_bytes.delete();
    case (k)
      ksq_pkg::KIND_KEY:        predict_key_event(c);
      ksq_pkg::KIND_RST_SEND:   release_every_key(1'b1);
      ksq_pkg::KIND_RST_SILENT: release_every_key(1'b0);
      default: ;
    endcase
    for (int i = 0; i < burst_bytes.size(); i++) begin
      e.scan = burst_bytes[i];
      e.fin = (i == burst_bytes.size() - 1);
      pending_bytes.push_back(e);
    end
  endfunction

  always @(posedge clk) begin
    scan_exp_t e;
    if (!rst && out_valid && out_ready) begin
      bytes_checked++;
      rx_stall_left = rx_idle ? $urandom_range(0, 16) : 0;
      if (pending_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected byte %02h last %0b with nothing pending", scan_byte, last);
      end else begin
        e = pending_bytes.pop_front();
        if (scan_byte !== e.scan || last !== e.fin) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                     e.scan, e.fin, scan_byte, last);
        end
      end
    end
  end

  initial begin
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_ready = 1'b0;
        rx_hold_left--;
      end else if (rx_stall_left > 0) begin
        out_ready = 1'b0;
        rx_stall_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_item(input logic [1:0] k, input logic [9:0] c);
    int gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    kind = k;
    code = c;
    do @(posedge clk); while (!in_ready);
    predict_scancodes(k, c);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_key(input logic [9:0] c);
    send_item(ksq_pkg::KIND_KEY, c);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_compose(input logic [6:0] value);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    compose_now = value;
  endtask

  task automatic test_key_events();
    send_key(10'h01E);
    send_key(10'h11D);
    send_key(10'h09E);
    send_key(10'h09E);
    send_key(10'h11D);
    send_key(ksq_pkg::CODE_PAUSE);
    send_key(10'h2AA);
    send_key(10'h3FF);
    send_key(10'h1FF);
    send_item(KIND_UNUSED, 10'h3FF);
    send_key(10'h000);
    send_key(10'h17F);
    send_item(ksq_pkg::KIND_RST_SEND, 10'h000);
    send_key(10'h005);
    send_item(ksq_pkg::KIND_RST_SILENT, 10'h000);
    send_key(10'h085);
    send_item(ksq_pkg::KIND_RST_SEND, 10'h3FF);
  endtask

  // The sender waits for every byte between items so that each compose case
  // starts from a quiet block.
  task automatic test_compose_key();
    logic [9:0] steps [12];
    steps = '{10'h057, 10'h0D7, 10'h0D7, 10'h057, 10'h010, 10'h090,
              10'h11E, 10'h0D7, 10'h020, 10'h057, 10'h0A0, 10'h0D7};
    send_item(ksq_pkg::KIND_RST_SILENT, 10'h000);
    foreach (steps[i]) begin
      wait_drained();
      send_key(steps[i]);
    end
  endtask

  task automatic test_full_map();
    send_item(ksq_pkg::KIND_RST_SILENT, 10'h000);
    for (int i = 0; i < HELD_LIMIT; i++)
      send_key({1'b0, i[0], 1'b0, 7'(i / 2 + 1)});
    send_key(10'h028);
    send_key(10'h001);
    send_key(10'h081);
    send_key(10'h028);
    send_key(10'h029);
    send_item(ksq_pkg::KIND_RST_SEND, 10'h000);
  endtask

  task automatic test_receiver_holdoff();
    wait_drained();
    rx_hold_left = 600;
    for (int i = 0; i < 8; i++)
      send_key({3'b000, 7'(i + 40)});
    send_item(ksq_pkg::KIND_RST_SEND, 10'h000);
    send_key(ksq_pkg::CODE_PAUSE);
  endtask

  task automatic random_item(ref logic [9:0] pool [12]);
    int sel;
    logic [9:0] pick;
    sel = $urandom_range(0, 99);
    pick = pool[$urandom_range(0, 11)];
    if (sel < 35) send_key(pick);
    else if (sel < 65) send_key(pick | 10'h080);
    else if (sel < 72) send_key({3'b000, compose_now});
    else if (sel < 78) send_key({3'b001, compose_now});
    else if (sel < 83) send_item(ksq_pkg::KIND_RST_SEND, 10'($urandom));
    else if (sel < 86) send_item(ksq_pkg::KIND_RST_SILENT, 10'($urandom));
    else if (sel < 88) send_item(KIND_UNUSED, 10'($urandom));
    else if (sel < 91) send_key(ksq_pkg::CODE_PAUSE);
    else send_key(10'($urandom));
  endtask

  task automatic test_random_traffic();
    logic [6:0] settings [4];
    logic [9:0] pool [12];
    int counted;
    settings = '{7'h00, 7'h7F, 7'($urandom), ksq_pkg::COMPOSE_RESET};
    for (int p = 0; p < 4; p++) begin
      write_compose(settings[p]);
      tx_idle = (p != 1) && (p != 2);
      rx_idle = (p != 1) && (p != 3);
      for (int j = 0; j < 12; j++)
        pool[j] = {1'b0, 1'($urandom), 1'b0, 7'($urandom)};
      pool[0] = {3'b000, compose_now};
      counted = 0;
      while (counted < 6) begin
        random_item(pool);
        if (kind != KIND_UNUSED) counted++;
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < NUM_KEYS; i++) key_down[i] = 1'b0;
    held_total = 0;
    compose_now = ksq_pkg::COMPOSE_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_key_events();
    test_compose_key();
    test_full_map();
    test_receiver_holdoff();
    test_random_traffic();

    wait_idle();
    $display("Sent %0d items covering key events, compose mode, a full held-key map,",
             items_sent);
    $display("resets and a long receiver stall; checked %0d scancode bytes.", bytes_checked);
    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d bytes never arrived", mismatch_count,
               pending_bytes.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
